// ===== hw/rtl/kst_pkg.sv =====
// package: codes, state constants and translation tables for the scan code translator
package kst_pkg;

  // host command codes watched on port 0
  localparam logic [7:0] CMD_SET_MATRIX = 8'hf7;
  localparam logic [7:0] CMD_READ_ID    = 8'hf2;
  localparam logic [7:0] CMD_SCAN_SET   = 8'hf0;
  localparam logic [7:0] CMD_RESET      = 8'hff;
  localparam logic [7:0] ARG_QUERY      = 8'h00;
  localparam logic [7:0] ARG_SET_ONE    = 8'h01;
  localparam logic [7:0] ARG_SET_TWO    = 8'h02;

  // scan codes and matrix codes
  localparam logic [7:0] BREAK_CODE     = 8'hf0;
  localparam logic [7:0] PREFIX_EXT     = 8'he0;
  localparam logic [7:0] MATRIX_FN      = 8'h81;
  localparam logic [7:0] REPLY_SET_TWO  = 8'h02;
  localparam logic [7:0] REPLY_SET_ONE  = 8'h01;

  // selected output set
  localparam logic [1:0] SET_OFF = 2'd0;
  localparam logic [1:0] SET_ONE = 2'd1;
  localparam logic [1:0] SET_TWO = 2'd2;

  // response byte counts
  localparam logic [1:0] PT_ONE   = 2'd1;
  localparam logic [1:0] PT_TWO   = 2'd2;
  localparam logic [1:0] PT_THREE = 2'd3;

  localparam int SPECIAL_COUNT = 52;
  localparam int MAX_RESULTS   = 3;

  typedef logic [7:0] byte_t;
  typedef logic [1:0] count_t;

  // matrix code to set 2 code; bit 7 marks a special key
  localparam byte_t MATRIX_MAP [128] = '{
    8'h80,8'h80,8'h14,8'h80,8'h80,8'h80,8'h80,8'ha2, 8'h0e,8'h8b,8'h0d,8'h0e,8'h1c,8'h1a,8'ha7,8'h15,
    8'h8c,8'h92,8'h90,8'h8e,8'h23,8'h21,8'ha9,8'h24, 8'h80,8'ha5,8'h80,8'h80,8'h80,8'ha6,8'h80,8'h8d,
    8'h32,8'h34,8'h2c,8'hab,8'h2b,8'h2a,8'haa,8'h2d, 8'h99,8'h97,8'h95,8'h93,8'h1b,8'h22,8'ha8,8'h1d,
    8'h84,8'h93,8'h5b,8'h5d,8'h42,8'h41,8'hae,8'h43, 8'ha3,8'h9f,8'h9d,8'h81,8'h9b,8'h98,8'h96,8'h8f,
    8'h31,8'h33,8'h35,8'hac,8'h3b,8'h3a,8'had,8'h3c, 8'h80,8'h80,8'h80,8'h80,8'h80,8'h12,8'h80,8'h85,
    8'hb2,8'h52,8'h54,8'hb1,8'h4c,8'h4a,8'hb0,8'h4d, 8'ha0,8'h9e,8'h9c,8'h9a,8'h4b,8'h49,8'haf,8'h44,
    8'h80,8'h80,8'h80,8'ha1,8'h80,8'h80,8'h80,8'h91, 8'ha4,8'h80,8'h80,8'h80,8'h80,8'h80,8'h11,8'h94,
    8'h82,8'hb3,8'h80,8'h5d,8'h5a,8'h86,8'h89,8'h88, 8'h83,8'h95,8'h5b,8'h55,8'h80,8'h52,8'h8a,8'h87
  };

  // special keys without function shift; bit 7 = extended prefix, zero = no event
  localparam byte_t SPECIAL_PLAIN [SPECIAL_COUNT] = '{
    8'h00,8'h0f,8'hf0,8'hf1,8'h51,8'h59,8'h29,8'heb,8'hf5,8'hf2,8'hf4,8'h76,8'h05,
    8'h00,8'h06,8'h00,8'h04,8'h00,8'h0c,8'h03,8'h00,8'h0b,8'h00,8'h02,8'h00,8'h0a,
    8'h01,8'h00,8'h09,8'h00,8'h78,8'h00,8'h07,8'haf,8'he4,8'hd7,8'h91,8'h9f,8'ha7,
    8'h16,8'h1e,8'h26,8'h25,8'h2e,8'h36,8'h3d,8'h3e,8'h46,8'h45,8'h4e,8'h55,8'h66
  };

  // special keys with function shift held
  localparam byte_t SPECIAL_FN [SPECIAL_COUNT] = '{
    8'h00,8'h0f,8'hf0,8'hf1,8'h6d,8'hf0,8'he1,8'hec,8'hfd,8'hfa,8'he9,8'hf6,8'h85,
    8'he2,8'h86,8'hdf,8'h84,8'hdc,8'h8c,8'h83,8'hd3,8'h8b,8'hd1,8'h82,8'hb9,8'h8a,
    8'h81,8'h99,8'h89,8'h93,8'hf8,8'hef,8'h87,8'h97,8'he3,8'h88,8'h91,8'h9f,8'ha7,
    8'h05,8'h06,8'h04,8'h0c,8'h03,8'h0b,8'h02,8'h0a,8'h01,8'h09,8'h78,8'h07,8'hf1
  };

  // set 2 code to set 1 code
  localparam byte_t SET1_MAP [128] = '{
    8'hff,8'h43,8'h41,8'h3f,8'h3d,8'h3b,8'h3c,8'h58, 8'h64,8'h44,8'h42,8'h40,8'h3e,8'h0f,8'h29,8'h59,
    8'h65,8'h38,8'h2a,8'h70,8'h1d,8'h10,8'h02,8'h5a, 8'hb4,8'h71,8'h2c,8'h1f,8'h1e,8'h11,8'h03,8'h5b,
    8'h67,8'h2e,8'h2d,8'h20,8'h12,8'h05,8'h04,8'h5c, 8'h68,8'h39,8'h2f,8'h21,8'h14,8'h13,8'h06,8'h5d,
    8'h69,8'h31,8'h30,8'h23,8'h22,8'h15,8'h07,8'h5e, 8'h6a,8'h72,8'h32,8'h24,8'h16,8'h08,8'h09,8'h5f,
    8'h6b,8'h33,8'h25,8'h17,8'h18,8'h0b,8'h0a,8'h60, 8'h6c,8'h34,8'h35,8'h26,8'h27,8'h19,8'h0c,8'h61,
    8'h6d,8'h73,8'h28,8'h74,8'h1a,8'h0d,8'h62,8'h6e, 8'h3a,8'h36,8'h1c,8'h1b,8'h75,8'h2b,8'h63,8'h76,
    8'h55,8'h56,8'h77,8'h78,8'h79,8'h7a,8'h0e,8'h7b, 8'h7c,8'h4f,8'h7d,8'h4b,8'h47,8'h7e,8'h7f,8'h6f,
    8'h52,8'h53,8'h50,8'h4c,8'h4d,8'h48,8'h01,8'h45, 8'h57,8'h4e,8'h51,8'h4a,8'h37,8'h49,8'h46,8'h54
  };

endpackage

// ===== hw/rtl/kst_in_if.sv =====
// interface: request channel carrying device bytes and host commands
interface kst_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic       port;
  logic [7:0] data_byte;

  modport source (output valid, output kind, output port, output data_byte, input ready);
  modport sink   (input valid, input kind, input port, input data_byte, output ready);
endinterface

// ===== hw/rtl/kst_out_if.sv =====
// interface: result channel carrying upstream bytes
interface kst_out_if;
  logic       valid;
  logic       ready;
  logic       out_port;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output out_port, output out_byte, output last, input ready);
  modport sink   (input valid, input out_port, input out_byte, input last, output ready);
endinterface

// ===== hw/rtl/keyboard_scan_code_translator_top.sv =====
// Keyboard scan code translator: takes device bytes and host command bytes on one
// request channel and gives upstream bytes on the result channel. A request is
// translated in the cycle it is taken; its zero to three result bytes sit in a
// three-entry output shift register and leave one per cycle while the result
// channel is ready. The next request is taken as soon as the last byte of the
// previous one is being taken, and command requests yield no result bytes.
module keyboard_scan_code_translator_top (
  input  logic clk,
  input  logic rst,
  kst_in_if.sink    req,
  kst_out_if.source rsp
);
  import kst_pkg::*;

  // translator state
  logic [1:0] output_set;
  logic       break_pending;
  logic       fn_held;
  logic [1:0] passthrough_left;
  byte_t      previous_command;

  logic [1:0] output_set_next;
  logic       break_pending_next;
  logic       fn_held_next;
  logic [1:0] passthrough_left_next;
  byte_t      previous_command_next;

  // output shift register
  byte_t      res_buf [MAX_RESULTS];
  count_t     res_cnt;
  logic       res_port;

  byte_t      new_buf [MAX_RESULTS];
  count_t     new_cnt;

  logic       in_take;
  logic       out_take;

  byte_t      kv;
  byte_t      sp;
  logic [6:0] code;
  logic       ext;
  logic       fn_sel;
  byte_t      pass_byte;
  byte_t      set1_code;

  assign out_take  = rsp.valid && rsp.ready;
  assign req.ready = (res_cnt == 2'd0) || ((res_cnt == 2'd1) && rsp.ready);
  assign in_take   = req.valid && req.ready;

  assign rsp.valid    = (res_cnt != 2'd0);
  assign rsp.out_byte = res_buf[0];
  assign rsp.out_port = res_port;
  assign rsp.last     = (res_cnt == 2'd1);

  // translation of one request and next state
  always_comb begin
    output_set_next       = output_set;
    break_pending_next    = break_pending;
    fn_held_next          = fn_held;
    passthrough_left_next = passthrough_left;
    previous_command_next = previous_command;
    new_buf               = '{default: 8'h00};
    new_cnt               = 2'd0;
    kv                    = 8'h00;
    sp                    = 8'h00;
    code                  = 7'h00;
    ext                   = 1'b0;
    fn_sel                = fn_held;
    pass_byte             = req.data_byte;
    set1_code             = 8'h00;

    if (req.kind) begin
      // host command watch, port 0 only
      if (!req.port) begin
        unique case (req.data_byte)
          CMD_SET_MATRIX: begin
            output_set_next       = SET_TWO;
            passthrough_left_next = PT_ONE;
          end
          CMD_READ_ID: passthrough_left_next = PT_THREE;
          CMD_RESET:   passthrough_left_next = PT_TWO;
          ARG_QUERY: begin
            passthrough_left_next = (previous_command == CMD_SCAN_SET) ? PT_TWO : PT_ONE;
          end
          ARG_SET_ONE: begin
            if (previous_command == CMD_SCAN_SET && output_set != SET_OFF)
              output_set_next = SET_ONE;
            passthrough_left_next = PT_ONE;
          end
          ARG_SET_TWO: begin
            if (previous_command == CMD_SCAN_SET && output_set != SET_OFF)
              output_set_next = SET_TWO;
            passthrough_left_next = PT_ONE;
          end
          default: passthrough_left_next = PT_ONE;
        endcase
        previous_command_next = req.data_byte;
      end
    end else if (req.port || output_set == SET_OFF || passthrough_left != 2'd0) begin
      // pass-through, with the scan set query reply spoofed
      if (!req.port && passthrough_left != 2'd0) begin
        if (previous_command == ARG_QUERY && output_set == SET_ONE &&
            req.data_byte == REPLY_SET_TWO)
          pass_byte = REPLY_SET_ONE;
        passthrough_left_next = passthrough_left - 2'd1;
      end
      new_buf[0] = pass_byte;
      new_cnt    = 2'd1;
    end else if (req.data_byte == BREAK_CODE) begin
      break_pending_next = 1'b1;
    end else begin
      // matrix lookup, high codes are no key
      kv = req.data_byte[7] ? 8'h80 : MATRIX_MAP[req.data_byte[6:0]];
      code = kv[6:0];
      if (kv[7]) begin
        if (kv == MATRIX_FN) begin
          fn_held_next = !break_pending;
          fn_sel       = !break_pending;
        end
        if (kv[6:0] < 7'(SPECIAL_COUNT))
          sp = fn_sel ? SPECIAL_FN[kv[5:0]] : SPECIAL_PLAIN[kv[5:0]];
        ext  = sp[7];
        code = sp[6:0];
      end
      if (kv[7] && sp == 8'h00) begin
        break_pending_next = 1'b0;
      end else begin
        // extended prefix, then release mark and code
        if (ext) begin
          new_buf[new_cnt] = PREFIX_EXT;
          new_cnt          = new_cnt + 2'd1;
        end
        if (output_set == SET_ONE) begin
          set1_code        = SET1_MAP[code];
          new_buf[new_cnt] = {set1_code[7] | break_pending, set1_code[6:0]};
          new_cnt          = new_cnt + 2'd1;
        end else begin
          if (break_pending) begin
            new_buf[new_cnt] = BREAK_CODE;
            new_cnt          = new_cnt + 2'd1;
          end
          new_buf[new_cnt] = {1'b0, code};
          new_cnt          = new_cnt + 2'd1;
        end
        break_pending_next = 1'b0;
      end
    end
  end

  // state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      output_set       <= SET_OFF;
      break_pending    <= 1'b0;
      fn_held          <= 1'b0;
      passthrough_left <= 2'd0;
      previous_command <= 8'h00;
      res_cnt          <= 2'd0;
    end else if (in_take) begin
      output_set       <= output_set_next;
      break_pending    <= break_pending_next;
      fn_held          <= fn_held_next;
      passthrough_left <= passthrough_left_next;
      previous_command <= previous_command_next;
      res_cnt          <= new_cnt;
    end else if (out_take) begin
      res_cnt <= res_cnt - 2'd1;
    end
  end

  // payload of the output register
  always_ff @(posedge clk) begin
    if (in_take) begin
      res_buf  <= new_buf;
      res_port <= req.port && !req.kind;
    end else if (out_take) begin
      res_buf[0] <= res_buf[1];
      res_buf[1] <= res_buf[2];
    end
  end

  // a request is taken only once the previous one is leaving
  assert property (@(posedge clk) disable iff (rst)
    in_take |-> (res_cnt == 2'd0) || (res_cnt == 2'd1 && out_take))
    else $error("request taken while results still pending");

  // pointing device bytes are always single results
  assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.out_port |-> rsp.last)
    else $error("port 1 result not single");

  // nothing to send straight after reset
  assert property (@(posedge clk) rst |=> !rsp.valid)
    else $error("result valid after reset");

  // a multi-byte result keeps going once started
  assert property (@(posedge clk) disable iff (rst)
    out_take && !rsp.last |=> rsp.valid && !req.ready || rsp.valid)
    else $error("result burst broken");

endmodule
